// ----- rtl/supply_voltage_window_monitor_defines.svh -----
// Assertion helpers used by the monitor top module.
`ifndef SUPPLY_VOLTAGE_WINDOW_MONITOR_DEFINES_SVH
`define SUPPLY_VOLTAGE_WINDOW_MONITOR_DEFINES_SVH

// Checked only outside reset.
`define SVWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, including reset cycles.
`define SVWM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/svwm_pkg.sv -----
package svwm_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned MV_W     = 16;
  localparam int unsigned DELTA_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DEB_W      = 3;

  localparam logic [DEB_W-1:0]  DEBOUNCE = 3'd5;
  localparam logic [TICK_W-1:0] PERIOD   = 32'd8;

  localparam logic [MV_W-1:0] MV_BASE      = 16'd1000;
  localparam logic [MV_W-1:0] SNAP_MV_INIT = 16'd11000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_COEF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_OFFS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDER_ON   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDER_OFF  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_ON    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_OFF   = 3'd6;

  typedef enum logic [1:0] {
    ST_INITIAL = 2'd0,
    ST_NORMAL  = 2'd1,
    ST_UNDER   = 2'd2,
    ST_OVER    = 2'd3
  } status_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [31:0] offset;
    logic [4:0]  shift;
  } cal_cfg_t;

endpackage

// ----- rtl/supply_voltage_window_monitor.sv -----
// Supply voltage window monitor.
//
// Input channel (in_valid/in_ready): one transaction per converter sample,
// carrying the raw 12-bit sample and the current free running tick.
// Result channel (out_valid/out_ready): exactly one transaction per input,
// in order: status class, calibrated mV, sense mV and the 8-bit change
// against the periodic snapshot.
// Configuration: cfg_we writes cfg_wdata to the register selected by
// cfg_index in the same edge; unknown indexes are dropped. Write only while
// the pipe is empty.
// Pipeline: input register -> calibration multiply-add-shift -> calibrated
// register -> classify/debounce/snapshot -> output register. A result passes
// the input, calibrated and output registers in turn; one transaction per
// cycle is sustained while out_ready is high, the class state loop not stalling it.
// Stall: when out_ready is low the output register holds, and the stages
// behind it fill before in_ready drops; nothing is lost or repeated.
// Reset (rst_n low, synchronous): pipe empties, registers take their default
// values, class returns to initial so the next sample is taken at once.
module supply_voltage_window_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [svwm_pkg::SAMPLE_W-1:0]   in_adc_sample,
  input  logic [svwm_pkg::TICK_W-1:0]     in_now_tick,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_supply_status,
  output logic [svwm_pkg::MV_W-1:0]       out_supply_mv,
  output logic [svwm_pkg::MV_W-1:0]       out_sense_mv,
  output logic [svwm_pkg::DELTA_W-1:0]    out_sense_delta,
  input  logic                            cfg_we,
  input  logic [svwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [svwm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import svwm_pkg::*;

  `include "supply_voltage_window_monitor_defines.svh"

  // configuration
  cal_cfg_t    cal_r;
  logic [15:0] under_on_r, under_off_r, over_on_r, over_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.gain   <= 16'd1;
      cal_r.offset <= 32'd0;
      cal_r.shift  <= 5'd0;
      under_on_r   <= 16'd9000;
      under_off_r  <= 16'd9500;
      over_on_r    <= 16'd16000;
      over_off_r   <= 16'd16500;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN_COEF:  cal_r.gain   <= cfg_wdata[15:0];
        CFG_GAIN_OFFS:  cal_r.offset <= cfg_wdata;
        CFG_GAIN_SHIFT: cal_r.shift  <= cfg_wdata[4:0];
        CFG_UNDER_ON:   under_on_r   <= cfg_wdata[15:0];
        CFG_UNDER_OFF:  under_off_r  <= cfg_wdata[15:0];
        CFG_OVER_ON:    over_on_r    <= cfg_wdata[15:0];
        CFG_OVER_OFF:   over_off_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic a_valid_r, b_valid_r, out_valid_r;
  logic out_free, b_go, b_free, a_go;

  assign out_free = !out_valid_r || out_ready;
  assign b_go     = b_valid_r && out_free;
  assign b_free   = !b_valid_r || b_go;
  assign a_go     = a_valid_r && b_free;
  assign in_ready = !a_valid_r || a_go;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) a_valid_r <= in_valid;
      if (b_free) b_valid_r <= a_valid_r;
      if (out_free) out_valid_r <= b_valid_r;
    end
  end

  // stage A: captured sample
  logic [SAMPLE_W-1:0] a_sample_r;
  logic [TICK_W-1:0]   a_tick_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_sample_r <= in_adc_sample;
      a_tick_r   <= in_now_tick;
    end
  end

  logic [MV_W-1:0] cal_supply, cal_sense;

  svwm_calib u_calib (
    .sample    (a_sample_r),
    .cal       (cal_r),
    .supply_mv (cal_supply),
    .sense_mv  (cal_sense)
  );

  // stage B: calibrated value
  logic [MV_W-1:0]   b_supply_r, b_sense_r;
  logic [TICK_W-1:0] b_tick_r;

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_supply_r <= cal_supply;
      b_sense_r  <= cal_sense;
      b_tick_r   <= a_tick_r;
    end
  end

  // classification with hysteresis: the "on" limit applies while in that class
  status_t           status_r, status_nxt, cls;
  logic [DEB_W-1:0]  debounce_r, debounce_nxt;
  logic [MV_W-1:0]   snap_mv_r, snap_mv_nxt;
  logic [TICK_W-1:0] snap_tick_r, snap_tick_nxt;
  logic [MV_W-1:0]   lo_lim, hi_lim;
  logic [TICK_W-1:0] tick_diff;
  logic              refresh;
  logic [MV_W-1:0]   delta;

  always_comb begin
    case (status_r)
      ST_UNDER: begin
        lo_lim = under_on_r;
        hi_lim = over_off_r;
      end
      ST_OVER: begin
        lo_lim = under_off_r;
        hi_lim = over_on_r;
      end
      default: begin
        lo_lim = under_off_r;
        hi_lim = over_off_r;
      end
    endcase

    // under wins even with crossed limits
    if (b_supply_r < lo_lim) cls = ST_UNDER;
    else if (b_supply_r > hi_lim) cls = ST_OVER;
    else cls = ST_NORMAL;

    status_nxt   = status_r;
    debounce_nxt = DEBOUNCE;
    if (status_r == ST_INITIAL) begin
      status_nxt = cls;
    end else if (cls != status_r) begin
      if (debounce_r <= 3'd1) status_nxt = cls;
      else debounce_nxt = debounce_r - 3'd1;
    end

    // snapshot refresh once the tick is strictly past snapshot + PERIOD
    tick_diff     = b_tick_r - (snap_tick_r + PERIOD);
    refresh       = (tick_diff != '0) && !tick_diff[TICK_W-1];
    snap_mv_nxt   = refresh ? b_sense_r : snap_mv_r;
    snap_tick_nxt = refresh ? b_tick_r : snap_tick_r;

    if (b_sense_r < snap_mv_nxt) delta = snap_mv_nxt - b_sense_r;
    else delta = b_sense_r - snap_mv_nxt;
  end

  logic [1:0]         out_status_r;
  logic [MV_W-1:0]    out_supply_r, out_sense_r;
  logic [DELTA_W-1:0] out_delta_r;

  // state advances together with the output register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= ST_INITIAL;
      debounce_r  <= DEBOUNCE;
      snap_mv_r   <= SNAP_MV_INIT;
      snap_tick_r <= '0;
    end else if (b_go) begin
      status_r    <= status_nxt;
      debounce_r  <= debounce_nxt;
      snap_mv_r   <= snap_mv_nxt;
      snap_tick_r <= snap_tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      out_status_r <= status_nxt;
      out_supply_r <= b_supply_r;
      out_sense_r  <= b_sense_r;
      out_delta_r  <= delta[DELTA_W-1:0];
    end
  end

  assign out_supply_status = out_status_r;
  assign out_supply_mv     = out_supply_r;
  assign out_sense_mv      = out_sense_r;
  assign out_sense_delta   = out_delta_r;

  // checks
  `SVWM_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_r && !b_valid_r && status_r == ST_INITIAL, "reset did not empty pipe")
  `SVWM_ASSERT(a_no_return_initial, status_r != ST_INITIAL |=> status_r != ST_INITIAL, "class went back to initial")
  `SVWM_ASSERT(a_deb_range, debounce_r != '0 && debounce_r <= DEBOUNCE, "debounce count out of range")
  `SVWM_ASSERT(a_out_matches_state, out_valid_r |-> out_status_r == status_r, "held result disagrees with class")
  `SVWM_ASSERT(a_change_after_debounce, b_go && status_r != ST_INITIAL && status_nxt != status_r |-> debounce_r <= 3'd1, "class changed before debounce expired")

endmodule

// ----- rtl/svwm_calib.sv -----
module svwm_calib (
  input  logic [svwm_pkg::SAMPLE_W-1:0] sample,
  input  svwm_pkg::cal_cfg_t            cal,
  output logic [svwm_pkg::MV_W-1:0]     supply_mv,
  output logic [svwm_pkg::MV_W-1:0]     sense_mv
);
  import svwm_pkg::*;

  logic [SAMPLE_W:0] doubled;
  logic [28:0]       prod;
  logic [31:0]       sum;
  logic [31:0]       shifted;

  // 16 x 13 bits never exceeds 29 bits, so the product never wraps; the offset add and the MV_BASE add can
  assign doubled   = {sample, 1'b0};
  assign prod      = {13'd0, cal.gain} * {16'd0, doubled};
  assign sum       = {3'b000, prod} + cal.offset;
  assign shifted   = sum >> cal.shift;
  assign sense_mv  = shifted[MV_W-1:0];
  assign supply_mv = shifted[MV_W-1:0] + MV_BASE;

endmodule
